@@ rtl/i2cbm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2cbm_pkg;

    localparam int unsigned TIMEOUT_W = 15;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 15'd200;

    localparam logic [2:0] CMD_START = 3'd0;
    localparam logic [2:0] CMD_STOP  = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_WACK  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [1:0] ACK_OK       = 2'd0;
    localparam logic [1:0] ACK_TIMEOUT  = 2'd1;
    localparam logic [1:0] ACK_UNSTABLE = 2'd2;

    typedef enum logic [13:0] {
        PH_IDLE     = 14'b00000000000001,
        PH_START_A  = 14'b00000000000010,
        PH_START_B  = 14'b00000000000100,
        PH_STOP     = 14'b00000000001000,
        PH_WR_LOW   = 14'b00000000010000,
        PH_WR_HIGH  = 14'b00000000100000,
        PH_ACK_WAIT = 14'b00000001000000,
        PH_ACK_HIGH = 14'b00000010000000,
        PH_ACK_LOW  = 14'b00000100000000,
        PH_RD_LOW   = 14'b00001000000000,
        PH_RD_HIGH  = 14'b00010000000000,
        PH_RD_GAP   = 14'b00100000000000,
        PH_RD_ACK   = 14'b01000000000000,
        PH_RD_END   = 14'b10000000000000
    } phase_t;

    typedef struct packed {
        phase_t                 phase;
        logic [2:0]             bit_count;
        logic [7:0]             shift_reg;
        logic [TIMEOUT_W-1:0]   wait_count;
        logic                   scl_drive;
        logic                   sda_drive;
        logic                   ack_mode;
        logic [7:0]             last_rx;
        logic [1:0]             last_ack;
    } state_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic [1:0] ack_status;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/i2cbm_step.sv @@
`timescale 1ns / 1ps
`default_nettype none

module i2cbm_step (
    input  wire i2cbm_pkg::state_t                  cur,
    input  wire i2cbm_pkg::item_t                   item,
    input  wire logic [i2cbm_pkg::TIMEOUT_W-1:0]    timeout,
    output i2cbm_pkg::state_t                       nxt,
    output i2cbm_pkg::result_t                      res
);

    always_comb
    begin
        i2cbm_pkg::state_t s;
        logic busy;
        logic done;
        logic scl_low_after;
        logic sda_rel_after;

        s             = cur;
        done          = 1'b0;
        scl_low_after = 1'b0;
        sda_rel_after = 1'b0;

        // take a new command only when idle; unknown codes are dropped
        if (s.phase == i2cbm_pkg::PH_IDLE && item.cmd_valid)
        begin
            case (item.cmd)
                i2cbm_pkg::CMD_START: s.phase = i2cbm_pkg::PH_START_A;
                i2cbm_pkg::CMD_STOP:  s.phase = i2cbm_pkg::PH_STOP;
                i2cbm_pkg::CMD_WRITE:
                begin
                    s.phase     = i2cbm_pkg::PH_WR_LOW;
                    s.bit_count = 3'd7;
                    s.shift_reg = item.tx_byte;
                end
                i2cbm_pkg::CMD_WACK:
                begin
                    s.phase      = i2cbm_pkg::PH_ACK_WAIT;
                    s.wait_count = timeout;
                end
                i2cbm_pkg::CMD_READ:
                begin
                    s.phase     = i2cbm_pkg::PH_RD_LOW;
                    s.bit_count = 3'd7;
                    s.shift_reg = 8'd0;
                    s.ack_mode  = item.send_ack;
                end
                default: ;
            endcase
        end

        busy = (s.phase != i2cbm_pkg::PH_IDLE);

        case (s.phase)
            i2cbm_pkg::PH_IDLE: ;
            i2cbm_pkg::PH_START_A:
            begin
                s.scl_drive = 1'b1;
                s.sda_drive = 1'b1;
                s.phase     = i2cbm_pkg::PH_START_B;
            end
            i2cbm_pkg::PH_START_B:
            begin
                s.sda_drive   = 1'b0;
                done          = 1'b1;
                scl_low_after = 1'b1;
                s.phase       = i2cbm_pkg::PH_IDLE;
            end
            i2cbm_pkg::PH_STOP:
            begin
                s.scl_drive   = 1'b1;
                s.sda_drive   = 1'b0;
                done          = 1'b1;
                sda_rel_after = 1'b1;
                s.phase       = i2cbm_pkg::PH_IDLE;
            end
            i2cbm_pkg::PH_WR_LOW:
            begin
                s.scl_drive = 1'b0;
                s.sda_drive = s.shift_reg[s.bit_count];
                s.phase     = i2cbm_pkg::PH_WR_HIGH;
            end
            i2cbm_pkg::PH_WR_HIGH:
            begin
                s.scl_drive = 1'b1;
                if (s.bit_count == 3'd0)
                begin
                    done          = 1'b1;
                    scl_low_after = 1'b1;
                    sda_rel_after = 1'b1;
                    s.phase       = i2cbm_pkg::PH_IDLE;
                end
                else
                begin
                    s.bit_count = s.bit_count - 3'd1;
                    s.phase     = i2cbm_pkg::PH_WR_LOW;
                end
            end
            i2cbm_pkg::PH_ACK_WAIT:
            begin
                // counter at zero times out whatever SDA shows
                if (s.wait_count == '0)
                begin
                    s.last_ack = i2cbm_pkg::ACK_TIMEOUT;
                    done       = 1'b1;
                    s.phase    = i2cbm_pkg::PH_IDLE;
                end
                else
                begin
                    s.wait_count = s.wait_count - {{(i2cbm_pkg::TIMEOUT_W-1){1'b0}}, 1'b1};
                    if (!item.sda_in)
                        s.phase = i2cbm_pkg::PH_ACK_HIGH;
                end
            end
            i2cbm_pkg::PH_ACK_HIGH:
            begin
                s.scl_drive = 1'b1;
                if (item.sda_in)
                begin
                    s.last_ack = i2cbm_pkg::ACK_UNSTABLE;
                    done       = 1'b1;
                    s.phase    = i2cbm_pkg::PH_IDLE;
                end
                else
                    s.phase = i2cbm_pkg::PH_ACK_LOW;
            end
            i2cbm_pkg::PH_ACK_LOW:
            begin
                s.scl_drive = 1'b0;
                s.last_ack  = i2cbm_pkg::ACK_OK;
                done        = 1'b1;
                s.phase     = i2cbm_pkg::PH_IDLE;
            end
            i2cbm_pkg::PH_RD_LOW:
            begin
                s.scl_drive = 1'b0;
                s.phase     = i2cbm_pkg::PH_RD_HIGH;
            end
            i2cbm_pkg::PH_RD_HIGH:
            begin
                s.scl_drive = 1'b1;
                if (item.sda_in)
                    s.shift_reg[s.bit_count] = 1'b1;
                if (s.bit_count == 3'd0)
                    s.phase = i2cbm_pkg::PH_RD_GAP;
                else
                begin
                    s.bit_count = s.bit_count - 3'd1;
                    s.phase     = i2cbm_pkg::PH_RD_LOW;
                end
            end
            i2cbm_pkg::PH_RD_GAP:
            begin
                s.scl_drive = 1'b0;
                s.phase     = i2cbm_pkg::PH_RD_ACK;
            end
            i2cbm_pkg::PH_RD_ACK:
            begin
                s.sda_drive = !s.ack_mode;
                s.scl_drive = 1'b1;
                s.phase     = i2cbm_pkg::PH_RD_END;
            end
            i2cbm_pkg::PH_RD_END:
            begin
                s.scl_drive   = 1'b0;
                sda_rel_after = s.ack_mode;
                s.last_rx     = s.shift_reg;
                done          = 1'b1;
                s.phase       = i2cbm_pkg::PH_IDLE;
            end
            default: s.phase = i2cbm_pkg::PH_IDLE;
        endcase

        res.scl_level  = s.scl_drive;
        res.sda_level  = s.sda_drive;
        res.busy_res   = busy;
        res.done_res   = done;
        res.rx_byte    = s.last_rx;
        res.ack_status = s.last_ack;

        // line changes that follow the tick's delay show from the next tick
        if (scl_low_after)
            s.scl_drive = 1'b0;
        if (sda_rel_after)
            s.sda_drive = 1'b1;

        nxt = s;
    end

endmodule

`default_nettype wire

@@ rtl/i2c_bit_level_master.sv @@
// Timing: a tick transferred at the input passes the input register, then the
// result register; it waits in the input register while the output stalls.
// Throughput: one tick per cycle unless the output stalls; the sequencer state
// and the result register update together from one pass of the phase logic.
// Reset: asynchronous, active low; lines released, phase idle, ack_timeout 200,
// received byte and ack status zero, no item held.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bit_level_master (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               cmd_valid,
    input  wire logic [2:0]                         cmd,
    input  wire logic [7:0]                         tx_byte,
    input  wire logic                               send_ack,
    input  wire logic                               sda_in,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic                                    scl_level,
    output logic                                    sda_level,
    output logic                                    busy_res,
    output logic                                    done_res,
    output logic [7:0]                              rx_byte,
    output logic [1:0]                              ack_status,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [i2cbm_pkg::TIMEOUT_W-1:0]    ack_timeout
);

    logic [i2cbm_pkg::TIMEOUT_W-1:0] timeout_reg;
    logic                 in_vld_reg;
    i2cbm_pkg::item_t     item_reg;
    i2cbm_pkg::state_t    state_reg;
    i2cbm_pkg::state_t    state_next;
    logic                 out_vld_reg;
    i2cbm_pkg::result_t   res_reg;
    i2cbm_pkg::result_t   res_next;
    logic                 advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            timeout_reg <= i2cbm_pkg::TIMEOUT_RESET;
        else if (cfg_valid && cfg_ready)
            timeout_reg <= ack_timeout;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.cmd_valid <= cmd_valid;
            item_reg.cmd       <= cmd;
            item_reg.tx_byte   <= tx_byte;
            item_reg.send_ack  <= send_ack;
            item_reg.sda_in    <= sda_in;
        end
        if (advance)
            res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= i2cbm_pkg::PH_IDLE;
            state_reg.bit_count  <= 3'd7;
            state_reg.shift_reg  <= 8'd0;
            state_reg.wait_count <= '0;
            state_reg.scl_drive  <= 1'b1;
            state_reg.sda_drive  <= 1'b1;
            state_reg.ack_mode   <= 1'b0;
            state_reg.last_rx    <= 8'd0;
            state_reg.last_ack   <= i2cbm_pkg::ACK_OK;
        end
        else if (advance)
            state_reg <= state_next;
    end

    i2cbm_step u_step (
        .cur     (state_reg),
        .item    (item_reg),
        .timeout (timeout_reg),
        .nxt     (state_next),
        .res     (res_next)
    );

    assign out_valid  = out_vld_reg;
    assign scl_level  = res_reg.scl_level;
    assign sda_level  = res_reg.sda_level;
    assign busy_res   = res_reg.busy_res;
    assign done_res   = res_reg.done_res;
    assign rx_byte    = res_reg.rx_byte;
    assign ack_status = res_reg.ack_status;

    // sequencer state moves only when a tick passes to the result register
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer state changed without a tick transfer");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> busy_res)
        else $error("done reported outside a busy command");

    a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_vld_reg && out_vld_reg && !out_ready)
        else $error("input stalled without a blocked result");

    a_ack_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ack_status <= i2cbm_pkg::ACK_UNSTABLE)
        else $error("invalid acknowledge status code");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("processed tick produced no result");

endmodule

`default_nettype wire
